[rtl/core/imhq_pkg.sv]
// Package for the indexed max-heap queue: operation and status codes,
// sequencer states and the fixed field widths of the channels.
// No dependencies; used by the channel interfaces and the top level.
`timescale 1ns / 1ps
`default_nettype none

package imhq_pkg;

  localparam int unsigned FUNC_W   = 3;
  localparam int unsigned ID_W     = 8;
  localparam int unsigned KEY_IN_W = 32;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned COUNT_W  = 7;

  typedef enum logic [FUNC_W-1:0] {
    FN_PUSH      = 3'd0,
    FN_DEL_MAX   = 3'd1,
    FN_DEACT_MAX = 3'd2,
    FN_MODIFY    = 3'd3,
    FN_QUERY     = 3'd4,
    FN_PEEK      = 3'd5,
    FN_CLEAR     = 3'd6
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 3'd0,
    ST_EMPTY  = 3'd1,
    ST_FULL   = 3'd2,
    ST_ABSENT = 3'd3,
    ST_ACTIVE = 3'd4
  } status_e;

  typedef enum logic [4:0] {
    S_CLR,
    S_IDLE,
    S_DECODE,
    S_MAPWAIT,
    S_QKEY,
    S_TOPWAIT,
    S_LAST,
    S_UP,
    S_UPCMP,
    S_DN,
    S_DNL,
    S_DNR,
    S_DNCMP,
    S_PLACE,
    S_RDORG,
    S_RELOAD,
    S_DONE
  } state_e;

endpackage

`default_nettype wire

[rtl/core/imhq_in_if.sv]
// Request channel of the indexed max-heap queue: valid, ready and one request.
// Depends on imhq_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface imhq_in_if;
  logic                                  valid;
  logic                                  ready;
  logic [imhq_pkg::FUNC_W-1:0]           func;
  logic [imhq_pkg::ID_W-1:0]             entry_id;
  logic signed [imhq_pkg::KEY_IN_W-1:0]  key;

  modport source (output valid, func, entry_id, key, input ready);
  modport sink   (input valid, func, entry_id, key, output ready);
endinterface

`default_nettype wire

[rtl/core/imhq_out_if.sv]
// Response channel of the indexed max-heap queue: valid, ready and one response.
// Depends on imhq_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface imhq_out_if;
  logic                                  valid;
  logic                                  ready;
  logic [imhq_pkg::STATUS_W-1:0]         status;
  logic signed [imhq_pkg::KEY_IN_W-1:0]  out_key;
  logic [imhq_pkg::ID_W-1:0]             out_id;
  logic                                  present;
  logic                                  active;
  logic [imhq_pkg::COUNT_W-1:0]          count;

  modport source (output valid, status, out_key, out_id, present, active, count,
                  input ready);
  modport sink   (input valid, status, out_key, out_id, present, active, count,
                  output ready);
endinterface

`default_nettype wire

[rtl/core/indexed_max_heap_queue.sv]
// Indexed binary max-heap priority queue: heap memory, id position map memory
// and a small sequencer around one shared signed comparator.
// Depends on imhq_pkg, imhq_in_if and imhq_out_if.
//
//   channel | dir | carries
//   in_i    | in  | func, entry_id, key
//   out_o   | out | status, out_key, out_id, present, active, count
//
// One request at a time; ready is high only while the sequencer is idle.
// Push climbs the heap level by level, extract descends it, and modify
// descends and then climbs; the heap memory gives one read per step.
// Clear and reset sweep the map. A finished response waits in the output
// register while the next request is taken; the sequencer stalls at its end
// only if that register is full.
`timescale 1ns / 1ps
`default_nettype none

module indexed_max_heap_queue #(
  parameter int unsigned HEAP_CAPACITY = 64,
  parameter int unsigned ID_SPACE      = 256,
  parameter int unsigned KEY_WIDTH     = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  imhq_in_if.sink          in_i,
  imhq_out_if.source       out_o
);

  localparam int unsigned KW   = (KEY_WIDTH < 32) ? KEY_WIDTH : 32;
  localparam int unsigned PW   = (HEAP_CAPACITY > 2) ? $clog2(HEAP_CAPACITY) : 1;
  localparam int unsigned CW   = $clog2(HEAP_CAPACITY + 1);
  localparam int unsigned MW   = $clog2(HEAP_CAPACITY + 2);
  localparam int unsigned IDW  = (ID_SPACE > 2) ? $clog2(ID_SPACE) : 1;
  localparam int unsigned CMPW = PW + 2;

  typedef struct packed {
    logic [imhq_pkg::ID_W-1:0] id;
    logic signed [KW-1:0]      key;
  } entry_t;

  // Storage
  entry_t            heap_mem [HEAP_CAPACITY];
  logic [MW-1:0]     map_mem  [ID_SPACE];
  entry_t            hrd_q;
  logic [MW-1:0]     mrd_q;

  logic              heap_we;
  logic [PW-1:0]     heap_wa, hrd_addr;
  entry_t            heap_wd;
  logic              map_we;
  logic [IDW-1:0]    map_wa, mrd_addr;
  logic [MW-1:0]     map_wd;

  imhq_pkg::state_e  state_q, state_d;
  logic [IDW-1:0]    clr_idx_q, clr_idx_d;
  logic              clr_op_q, clr_op_d;
  logic [imhq_pkg::FUNC_W-1:0] func_q, func_d;
  logic [imhq_pkg::ID_W-1:0]   id_q, id_d;
  logic signed [KW-1:0]        key_q, key_d;
  entry_t            cur_q, cur_d, pick_q, pick_d;
  logic [PW-1:0]     pos_q, pos_d, org_q, org_d, pick_pos_q, pick_pos_d;
  logic              down_q, down_d;
  logic [CW-1:0]     count_q, count_d;

  logic [imhq_pkg::STATUS_W-1:0] res_status_q, res_status_d;
  logic signed [KW-1:0]          res_key_q, res_key_d;
  logic [imhq_pkg::ID_W-1:0]     res_id_q, res_id_d;
  logic                          res_pres_q, res_pres_d, res_act_q, res_act_d;

  logic                          out_valid_q, out_valid_d, out_load;
  logic [imhq_pkg::STATUS_W-1:0] out_status_q;
  logic signed [imhq_pkg::KEY_IN_W-1:0] out_key_q;
  logic [imhq_pkg::ID_W-1:0]     out_id_q;
  logic                          out_pres_q, out_act_q;
  logic [imhq_pkg::COUNT_W-1:0]  out_count_q;

  // Shared comparator and derived positions
  logic signed [KW-1:0] cmp_a, cmp_b;
  logic                 cmp_lt;
  logic                 id_ok, full, m_ge2, m_in, l_lt, r_lt;
  logic [MW-1:0]        m_pos;
  logic [CMPW-1:0]      l_w, r_w;
  logic [PW-1:0]        parent;
  logic [MW-1:0]        pos_code;

  assign cmp_lt   = cmp_a < cmp_b;
  assign id_ok    = 32'(id_q) < 32'(ID_SPACE);
  assign full     = count_q >= CW'(HEAP_CAPACITY);
  assign m_ge2    = mrd_q >= MW'(2);
  assign m_pos    = mrd_q - MW'(2);
  assign m_in     = m_ge2 && (CMPW'(m_pos) < CMPW'(count_q));
  assign l_w      = CMPW'({pos_q, 1'b1});
  assign r_w      = l_w + CMPW'(1);
  assign l_lt     = l_w < CMPW'(count_q);
  assign r_lt     = r_w < CMPW'(count_q);
  assign parent   = PW'((pos_q - PW'(1)) >> 1);
  assign pos_code = MW'(pos_q) + MW'(2);

  always_ff @(posedge clk_i) begin
    if (heap_we) begin
      heap_mem[heap_wa] <= heap_wd;
    end
    hrd_q <= heap_mem[hrd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (map_we) begin
      map_mem[map_wa] <= map_wd;
    end
    mrd_q <= map_mem[mrd_addr];
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      imhq_pkg::S_CLR: begin
        if (clr_idx_q == IDW'(ID_SPACE - 1)) begin
          state_d = clr_op_q ? imhq_pkg::S_DONE : imhq_pkg::S_IDLE;
        end
      end
      imhq_pkg::S_IDLE: begin
        if (in_i.valid) state_d = imhq_pkg::S_DECODE;
      end
      imhq_pkg::S_DECODE: begin
        unique case (func_q)
          imhq_pkg::FN_PUSH:
            state_d = (!id_ok || full) ? imhq_pkg::S_DONE : imhq_pkg::S_MAPWAIT;
          imhq_pkg::FN_DEL_MAX, imhq_pkg::FN_DEACT_MAX, imhq_pkg::FN_PEEK:
            state_d = (count_q == '0) ? imhq_pkg::S_DONE : imhq_pkg::S_TOPWAIT;
          imhq_pkg::FN_MODIFY, imhq_pkg::FN_QUERY:
            state_d = id_ok ? imhq_pkg::S_MAPWAIT : imhq_pkg::S_DONE;
          imhq_pkg::FN_CLEAR: state_d = imhq_pkg::S_CLR;
          default:            state_d = imhq_pkg::S_DONE;
        endcase
      end
      imhq_pkg::S_MAPWAIT: begin
        unique case (func_q)
          imhq_pkg::FN_PUSH:
            state_d = m_ge2 ? imhq_pkg::S_DONE : imhq_pkg::S_UP;
          imhq_pkg::FN_MODIFY:
            state_d = m_in ? imhq_pkg::S_DN : imhq_pkg::S_DONE;
          imhq_pkg::FN_QUERY:
            state_d = m_in ? imhq_pkg::S_QKEY : imhq_pkg::S_DONE;
          default: state_d = imhq_pkg::S_DONE;
        endcase
      end
      imhq_pkg::S_QKEY: state_d = imhq_pkg::S_DONE;
      imhq_pkg::S_TOPWAIT: begin
        state_d = (func_q == imhq_pkg::FN_PEEK) ? imhq_pkg::S_DONE : imhq_pkg::S_LAST;
      end
      imhq_pkg::S_LAST: begin
        state_d = (count_q == CW'(1)) ? imhq_pkg::S_DONE : imhq_pkg::S_DN;
      end
      imhq_pkg::S_UP: state_d = (pos_q == '0) ? imhq_pkg::S_PLACE : imhq_pkg::S_UPCMP;
      imhq_pkg::S_UPCMP: state_d = cmp_lt ? imhq_pkg::S_PLACE : imhq_pkg::S_UP;
      imhq_pkg::S_DN: state_d = l_lt ? imhq_pkg::S_DNL : imhq_pkg::S_PLACE;
      imhq_pkg::S_DNL: state_d = r_lt ? imhq_pkg::S_DNR : imhq_pkg::S_DNCMP;
      imhq_pkg::S_DNR: state_d = imhq_pkg::S_DNCMP;
      imhq_pkg::S_DNCMP: state_d = cmp_lt ? imhq_pkg::S_DN : imhq_pkg::S_PLACE;
      imhq_pkg::S_PLACE: begin
        state_d = (down_q && func_q == imhq_pkg::FN_MODIFY) ?
                  imhq_pkg::S_RDORG : imhq_pkg::S_DONE;
      end
      imhq_pkg::S_RDORG: state_d = imhq_pkg::S_RELOAD;
      imhq_pkg::S_RELOAD: state_d = imhq_pkg::S_UP;
      imhq_pkg::S_DONE: begin
        if (!out_valid_q || out_o.ready) state_d = imhq_pkg::S_IDLE;
      end
      default: state_d = imhq_pkg::S_IDLE;
    endcase
  end

  // Datapath control
  always_comb begin
    clr_idx_d    = clr_idx_q;
    clr_op_d     = clr_op_q;
    func_d       = func_q;
    id_d         = id_q;
    key_d        = key_q;
    cur_d        = cur_q;
    pick_d       = pick_q;
    pos_d        = pos_q;
    org_d        = org_q;
    pick_pos_d   = pick_pos_q;
    down_d       = down_q;
    count_d      = count_q;
    res_status_d = res_status_q;
    res_key_d    = res_key_q;
    res_id_d     = res_id_q;
    res_pres_d   = res_pres_q;
    res_act_d    = res_act_q;
    heap_we      = 1'b0;
    heap_wa      = pos_q;
    heap_wd      = cur_q;
    hrd_addr     = '0;
    map_we       = 1'b0;
    map_wa       = IDW'(cur_q.id);
    map_wd       = pos_code;
    mrd_addr     = IDW'(id_q);
    cmp_a        = cur_q.key;
    cmp_b        = hrd_q.key;
    out_load     = 1'b0;

    unique case (state_q)
      imhq_pkg::S_CLR: begin
        map_we    = 1'b1;
        map_wa    = clr_idx_q;
        map_wd    = '0;
        clr_idx_d = clr_idx_q + IDW'(1);
        if (clr_idx_q == IDW'(ID_SPACE - 1)) clr_op_d = 1'b0;
      end
      imhq_pkg::S_IDLE: begin
        if (in_i.valid) begin
          func_d       = in_i.func;
          id_d         = in_i.entry_id;
          key_d        = KW'(in_i.key);
          res_status_d = imhq_pkg::ST_OK;
          res_key_d    = '0;
          res_id_d     = '0;
          res_pres_d   = 1'b0;
          res_act_d    = 1'b0;
          down_d       = 1'b0;
        end
      end
      imhq_pkg::S_DECODE: begin
        unique case (func_q)
          imhq_pkg::FN_PUSH: begin
            if (!id_ok) res_status_d = imhq_pkg::ST_ABSENT;
            else if (full) res_status_d = imhq_pkg::ST_FULL;
          end
          imhq_pkg::FN_DEL_MAX, imhq_pkg::FN_DEACT_MAX, imhq_pkg::FN_PEEK: begin
            if (count_q == '0) res_status_d = imhq_pkg::ST_EMPTY;
          end
          imhq_pkg::FN_MODIFY, imhq_pkg::FN_QUERY: begin
            if (!id_ok) res_status_d = imhq_pkg::ST_ABSENT;
          end
          imhq_pkg::FN_CLEAR: begin
            count_d   = '0;
            clr_idx_d = '0;
            clr_op_d  = 1'b1;
          end
          default: ;
        endcase
      end
      imhq_pkg::S_MAPWAIT: begin
        unique case (func_q)
          imhq_pkg::FN_PUSH: begin
            if (m_ge2) begin
              res_status_d = imhq_pkg::ST_ACTIVE;
            end else begin
              pos_d   = PW'(count_q);
              count_d = count_q + CW'(1);
              cur_d   = '{id: id_q, key: key_q};
            end
          end
          imhq_pkg::FN_MODIFY: begin
            if (!m_in) begin
              res_status_d = imhq_pkg::ST_ABSENT;
            end else begin
              pos_d  = PW'(m_pos);
              org_d  = PW'(m_pos);
              cur_d  = '{id: id_q, key: key_q};
              down_d = 1'b1;
            end
          end
          imhq_pkg::FN_QUERY: begin
            res_pres_d = (mrd_q != '0);
            res_id_d   = id_q;
            hrd_addr   = PW'(m_pos);
          end
          default: ;
        endcase
      end
      imhq_pkg::S_QKEY: begin
        res_key_d = hrd_q.key;
        res_act_d = 1'b1;
      end
      imhq_pkg::S_TOPWAIT: begin
        res_key_d = hrd_q.key;
        res_id_d  = hrd_q.id;
        hrd_addr  = PW'(count_q - CW'(1));
      end
      imhq_pkg::S_LAST: begin
        // Last entry moves to root; the extracted id is dropped or deactivated.
        cur_d   = hrd_q;
        count_d = count_q - CW'(1);
        pos_d   = '0;
        down_d  = 1'b1;
        map_we  = 1'b1;
        map_wa  = IDW'(res_id_q);
        map_wd  = (func_q == imhq_pkg::FN_DEL_MAX) ? MW'(0) : MW'(1);
      end
      imhq_pkg::S_UP: begin
        hrd_addr = parent;
      end
      imhq_pkg::S_UPCMP: begin
        // Equal keys rise, so the parent moves down unless it is strictly larger.
        if (!cmp_lt) begin
          heap_we = 1'b1;
          heap_wd = hrd_q;
          map_we  = 1'b1;
          map_wa  = IDW'(hrd_q.id);
          pos_d   = parent;
        end
      end
      imhq_pkg::S_DN: begin
        hrd_addr = PW'(l_w);
      end
      imhq_pkg::S_DNL: begin
        pick_d     = hrd_q;
        pick_pos_d = PW'(l_w);
        hrd_addr   = PW'(r_w);
      end
      imhq_pkg::S_DNR: begin
        cmp_a = pick_q.key;
        if (cmp_lt) begin
          pick_d     = hrd_q;
          pick_pos_d = PW'(r_w);
        end
      end
      imhq_pkg::S_DNCMP: begin
        cmp_b = pick_q.key;
        if (cmp_lt) begin
          heap_we = 1'b1;
          heap_wd = pick_q;
          map_we  = 1'b1;
          map_wa  = IDW'(pick_q.id);
          pos_d   = pick_pos_q;
        end
      end
      imhq_pkg::S_PLACE: begin
        heap_we = 1'b1;
        map_we  = 1'b1;
      end
      imhq_pkg::S_RDORG: begin
        // A modified key climbs from its original slot after the descent.
        hrd_addr = org_q;
        down_d   = 1'b0;
      end
      imhq_pkg::S_RELOAD: begin
        cur_d = hrd_q;
        pos_d = org_q;
      end
      imhq_pkg::S_DONE: begin
        out_load = !out_valid_q || out_o.ready;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && !out_o.ready;
    if (out_load) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= imhq_pkg::S_CLR;
      clr_idx_q   <= '0;
      clr_op_q    <= 1'b0;
      count_q     <= '0;
      down_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_idx_q   <= clr_idx_d;
      clr_op_q    <= clr_op_d;
      count_q     <= count_d;
      down_q      <= down_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q       <= func_d;
    id_q         <= id_d;
    key_q        <= key_d;
    cur_q        <= cur_d;
    pick_q       <= pick_d;
    pos_q        <= pos_d;
    org_q        <= org_d;
    pick_pos_q   <= pick_pos_d;
    res_status_q <= res_status_d;
    res_key_q    <= res_key_d;
    res_id_q     <= res_id_d;
    res_pres_q   <= res_pres_d;
    res_act_q    <= res_act_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_key_q    <= imhq_pkg::KEY_IN_W'(res_key_q);
      out_id_q     <= res_id_q;
      out_pres_q   <= res_pres_q;
      out_act_q    <= res_act_q;
      out_count_q  <= imhq_pkg::COUNT_W'(count_q);
    end
  end

  assign in_i.ready    = (state_q == imhq_pkg::S_IDLE);
  assign out_o.valid   = out_valid_q;
  assign out_o.status  = out_status_q;
  assign out_o.out_key = out_key_q;
  assign out_o.out_id  = out_id_q;
  assign out_o.present = out_pres_q;
  assign out_o.active  = out_act_q;
  assign out_o.count   = out_count_q;

endmodule

`default_nettype wire

[tb/sv/imhq_checker.sv]
// Checker for the indexed max-heap queue: watches both channels, keeps its own
// copy of the heap and id position map, and compares every response in order.
// Depends on imhq_pkg, imhq_in_if and imhq_out_if.
`timescale 1ns / 1ps

module imhq_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  imhq_in_if         req,
  imhq_out_if        rsp,
  output int         errors_o,
  output int         pending_o,
  output int         responses_o
);

  localparam int CAP = 64;
  localparam int IDS = 256;

  typedef struct packed {
    logic [imhq_pkg::STATUS_W-1:0] status;
    logic signed [31:0]            out_key;
    logic [7:0]                    out_id;
    logic                          present;
    logic                          active;
    logic [imhq_pkg::COUNT_W-1:0]  count;
  } resp_t;

  logic signed [31:0] hk [CAP];
  logic [7:0]         hid [CAP];
  int                 posmap [IDS];
  int                 hcount;
  resp_t              awaited [$];
  int                 errors, responses;

  assign errors_o    = errors;
  assign pending_o   = awaited.size();
  assign responses_o = responses;

  function automatic void swap_slots(int a, int b);
    logic signed [31:0] tk;
    logic [7:0]         ti;
    if (a == b) return;
    tk = hk[a]; hk[a] = hk[b]; hk[b] = tk;
    ti = hid[a]; hid[a] = hid[b]; hid[b] = ti;
    posmap[hid[a]] = a + 2;
    posmap[hid[b]] = b + 2;
  endfunction

  function automatic void rise(int p);
    int par;
    while (p > 0) begin
      par = (p - 1) / 2;
      if (hk[p] < hk[par]) break;
      swap_slots(p, par);
      p = par;
    end
  endfunction

  function automatic void sink_down(int p);
    int l, r, pick;
    forever begin
      l = 2 * p + 1;
      r = l + 1;
      if (l >= hcount) break;
      pick = (r >= hcount || hk[l] >= hk[r]) ? l : r;
      if (!(hk[p] < hk[pick])) break;
      swap_slots(p, pick);
      p = pick;
    end
  endfunction

  function automatic resp_t apply_request(logic [2:0] fn, logic [7:0] id,
                                          logic signed [31:0] key);
    resp_t r;
    int    p, m;
    r = '0;
    r.status = imhq_pkg::ST_OK;
    case (fn)
      imhq_pkg::FN_PUSH: begin
        if (hcount >= CAP) r.status = imhq_pkg::ST_FULL;
        else if (posmap[id] >= 2) r.status = imhq_pkg::ST_ACTIVE;
        else begin
          p = hcount;
          hcount = hcount + 1;
          hk[p] = key; hid[p] = id; posmap[id] = p + 2;
          rise(p);
        end
      end
      imhq_pkg::FN_DEL_MAX, imhq_pkg::FN_DEACT_MAX: begin
        if (hcount == 0) r.status = imhq_pkg::ST_EMPTY;
        else begin
          r.out_key = hk[0];
          r.out_id  = hid[0];
          swap_slots(0, hcount - 1);
          hcount = hcount - 1;
          posmap[r.out_id] = (fn == imhq_pkg::FN_DEL_MAX) ? 0 : 1;
          sink_down(0);
        end
      end
      imhq_pkg::FN_MODIFY: begin
        if (posmap[id] < 2 || posmap[id] - 2 >= hcount) r.status = imhq_pkg::ST_ABSENT;
        else begin
          p = posmap[id] - 2;
          hk[p] = key;
          sink_down(p);
          rise(p);
        end
      end
      imhq_pkg::FN_QUERY: begin
        m = posmap[id];
        r.out_id  = id;
        r.present = (m != 0);
        if (m >= 2 && m - 2 < hcount) begin
          r.active  = 1'b1;
          r.out_key = hk[m - 2];
        end
      end
      imhq_pkg::FN_PEEK: begin
        if (hcount == 0) r.status = imhq_pkg::ST_EMPTY;
        else begin
          r.out_key = hk[0];
          r.out_id  = hid[0];
        end
      end
      imhq_pkg::FN_CLEAR: begin
        hcount = 0;
        foreach (posmap[i]) posmap[i] = 0;
      end
      default: ;
    endcase
    r.count = hcount[imhq_pkg::COUNT_W-1:0];
    return r;
  endfunction

  initial begin
    errors = 0;
    responses = 0;
    hcount = 0;
    foreach (posmap[i]) posmap[i] = 0;
  end

  always @(posedge clk_i) begin
    resp_t seen, want;
    if (rst_ni) begin
      if (rsp.valid && rsp.ready) begin
        seen = '{rsp.status, rsp.out_key, rsp.out_id, rsp.present, rsp.active,
                 rsp.count};
        responses++;
        if (awaited.size() == 0) begin
          errors++;
          $display("%0t: unexpected response %p", $time, seen);
        end else begin
          want = awaited.pop_front();
          if (seen !== want) begin
            errors++;
            $display("%0t: mismatch expected %p actual %p", $time, want, seen);
          end
        end
      end
      if (req.valid && req.ready)
        awaited.push_back(apply_request(req.func, req.entry_id, req.key));
    end
  end

endmodule

[tb/sv/tb.sv]
// Top of the indexed max-heap queue testbench: clock, reset, stimulus with
// random gaps and stalls, and the verdict. Depends on imhq_pkg, the channel
// interfaces, imhq_checker and the block itself.
`timescale 1ns / 1ps

module tb;

  // Function code with no operation behind it.
  localparam logic [2:0] FN_RESERVED = 3'd7;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   cycles = 0;
  int   errors, pending, responses;
  int   sent = 0;
  bit   stim_done = 0;

  imhq_in_if  req ();
  imhq_out_if rsp ();

  indexed_max_heap_queue uut (.clk_i(clk_i), .rst_ni(rst_ni), .in_i(req), .out_o(rsp));

  imhq_checker chk (.clk_i(clk_i), .rst_ni(rst_ni), .req(req), .rsp(rsp),
                    .errors_o(errors), .pending_o(pending), .responses_o(responses));

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("indexed_max_heap_queue test failed");
      $finish;
    end
  end

  // Valid stays high between back-to-back transfers and drops only for a gap.
  task automatic send(logic [2:0] fn, int id, int key);
    int gap;
    gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(17);
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req.valid    <= 1'b1;
    req.func     <= fn;
    req.entry_id <= 8'(id);
    req.key      <= key;
    do @(posedge clk_i); while (!req.ready);
    sent++;
  endtask

  function automatic int pick_key();
    case ($urandom_range(5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(7);
      default: return $urandom;
    endcase
  endfunction

  function automatic int pick_id();
    if ($urandom_range(3) == 0) return $urandom_range(255);
    return $urandom_range(79);
  endfunction

  // Response side stalls: draws a hold for every transfer.
  initial begin
    int hold;
    rsp.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      hold = ($urandom_range(3) == 0) ? 0 : $urandom_range(17);
      if (hold > 0) begin
        rsp.ready <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
      rsp.ready <= 1'b1;
      do @(posedge clk_i); while (!rsp.valid);
    end
  end

  initial begin
    int fn, phase_len;
    req.valid = 1'b0;
    req.func = imhq_pkg::FN_PEEK;
    req.entry_id = '0;
    req.key = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // Directed: empty-heap cases, extreme keys and ids, duplicates, absent ids.
    send(imhq_pkg::FN_PEEK, 0, 0);
    send(imhq_pkg::FN_DEL_MAX, 0, 0);
    send(imhq_pkg::FN_DEACT_MAX, 0, 0);
    send(imhq_pkg::FN_MODIFY, 5, 0);
    send(imhq_pkg::FN_QUERY, 255, 0);
    send(imhq_pkg::FN_PUSH, 0, 32'h80000000);
    send(imhq_pkg::FN_PUSH, 255, 32'h7fffffff);
    send(imhq_pkg::FN_PUSH, 255, 1);
    send(imhq_pkg::FN_PUSH, 7, 32'h7fffffff);
    send(imhq_pkg::FN_PUSH, 8, 32'hffffffff);
    send(imhq_pkg::FN_PEEK, 0, 0);
    send(imhq_pkg::FN_QUERY, 0, 0);
    send(imhq_pkg::FN_MODIFY, 0, 32'h7ffffffe);
    send(imhq_pkg::FN_DEACT_MAX, 0, 0);
    send(imhq_pkg::FN_QUERY, 255, 0);
    send(imhq_pkg::FN_MODIFY, 255, 3);
    send(imhq_pkg::FN_PUSH, 255, 3);
    send(imhq_pkg::FN_DEL_MAX, 0, 0);
    send(FN_RESERVED, 32'haa, 32'h55555555);
    send(imhq_pkg::FN_CLEAR, 0, 0);
    send(imhq_pkg::FN_QUERY, 7, 0);
    // Fill to capacity and two beyond, so the full case is reached.
    for (int i = 0; i < 65; i++) send(imhq_pkg::FN_PUSH, i, $urandom_range(3));
    send(imhq_pkg::FN_PUSH, 200, 0);
    for (int i = 0; i < 10; i++) send(imhq_pkg::FN_MODIFY, $urandom_range(63), pick_key());
    for (int i = 0; i < 66; i++)
      send($urandom_range(1) ? imhq_pkg::FN_DEL_MAX : imhq_pkg::FN_DEACT_MAX, 0, 0);
    // Random phases: push-heavy, mixed with everything else, some followed by a run of deletes.
    while (sent < 1300) begin
      phase_len = $urandom_range(20, 90);
      for (int i = 0; i < phase_len; i++) begin
        fn = $urandom_range(99);
        if (fn < 40)       send(imhq_pkg::FN_PUSH, pick_id(), pick_key());
        else if (fn < 55)  send(imhq_pkg::FN_DEL_MAX, 0, 0);
        else if (fn < 65)  send(imhq_pkg::FN_DEACT_MAX, 0, 0);
        else if (fn < 80)  send(imhq_pkg::FN_MODIFY, pick_id(), pick_key());
        else if (fn < 90)  send(imhq_pkg::FN_QUERY, pick_id(), 0);
        else if (fn < 97)  send(imhq_pkg::FN_PEEK, $urandom, $urandom);
        else if (fn < 98)  send(imhq_pkg::FN_CLEAR, 0, 0);
        else               send(FN_RESERVED, $urandom, $urandom);
      end
      if ($urandom_range(1)) for (int i = 0; i < 20; i++) send(imhq_pkg::FN_DEL_MAX, 0, 0);
    end
    req.valid <= 1'b0;
    stim_done = 1;
  end

  initial begin
    wait (stim_done);
    while (pending != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
    $display("Sent %0d requests covering push, extract, modify, query, peek,", sent);
    $display("clear and unused codes; %0d responses checked.", responses);
    if (errors == 0 && pending == 0) $display("indexed_max_heap_queue test passed");
    else $display("indexed_max_heap_queue test failed");
    $finish;
  end

endmodule
